/* rtl/mbi_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_pkg
// Types, constants and saturation helpers of the multichannel band-pass IIR.
// ============================================================================
package mbi_pkg;

    // Field and word widths
    localparam int CHANNELS   = 8;
    localparam int CHAN_W     = 3;
    localparam int ADDR_W     = $clog2(CHANNELS);
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 28;
    localparam int STATE_W    = 48;
    localparam int STATE_FRAC = 12;
    localparam int ACC_W      = STATE_W + 2;
    localparam int YQ_W       = 32;
    localparam int YQ_FRAC    = 32 - SAMPLE_W;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int TAPS       = 4;
    localparam int ROW_W      = TAPS * STATE_W;

    // Product alignment shifts
    localparam int SX       = COEF_FRAC - STATE_FRAC;
    localparam int SY       = COEF_FRAC + YQ_FRAC - STATE_FRAC;
    localparam int YQ_SHIFT = STATE_FRAC - YQ_FRAC;

    // Configuration port
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int NUM_REGS = 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [CHAN_W-1:0]   chan_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [STATE_W-1:0]  state_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [YQ_W-1:0]     yq_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic        [ROW_W-1:0]    row_t;

    typedef enum logic [2:0] {
        REG_GAIN = 3'd0,
        REG_A1   = 3'd1,
        REG_A2   = 3'd2,
        REG_A3   = 3'd3,
        REG_A4   = 3'd4
    } reg_idx_t;

    localparam coef_t GAIN_RST = coef_t'(23401957);
    localparam coef_t A1_RST   = coef_t'(-770867792);
    localparam coef_t A2_RST   = coef_t'(849479879);
    localparam coef_t A3_RST   = coef_t'(-441729137);
    localparam coef_t A4_RST   = coef_t'(96002709);

    typedef struct packed {
        coef_t gain;
        coef_t a1;
        coef_t a2;
        coef_t a3;
        coef_t a4;
    } cfg_t;

    typedef enum logic [2:0] {
        SEL_GAIN = 3'd0,
        SEL_A1   = 3'd1,
        SEL_A2   = 3'd2,
        SEL_A3   = 3'd3,
        SEL_A4   = 3'd4
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GAIN_RND,
        ST_GAIN_ACC,
        ST_QUANT,
        ST_FEEDBACK,
        ST_DRAIN_RND,
        ST_DRAIN_ACC,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic     capture;
        logic     load;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     quant;
        logic     commit;
    } dp_cmd_t;

    // Saturation limits in accumulator width
    localparam acc_t STATE_MAX_A  = acc_t'({1'b0, {(STATE_W-1){1'b1}}});
    localparam acc_t STATE_MIN_A  = ~STATE_MAX_A;
    localparam acc_t YQ_MAX_A     = acc_t'({1'b0, {(YQ_W-1){1'b1}}});
    localparam acc_t YQ_MIN_A     = ~YQ_MAX_A;
    localparam acc_t SAMPLE_MAX_A = acc_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam acc_t SAMPLE_MIN_A = ~SAMPLE_MAX_A;

    // Half-LSB rounding offsets
    localparam acc_t YQ_HALF  = acc_t'(1) <<< (YQ_SHIFT - 1);
    localparam acc_t OUT_HALF = acc_t'(1) <<< (STATE_FRAC - 1);

    function automatic state_t sat_state(input acc_t v);
        acc_t r;
        if (v > STATE_MAX_A)
            r = STATE_MAX_A;
        else if (v < STATE_MIN_A)
            r = STATE_MIN_A;
        else
            r = v;
        return r[STATE_W-1:0];
    endfunction

    function automatic yq_t sat_yq(input acc_t v);
        acc_t r;
        if (v > YQ_MAX_A)
            r = YQ_MAX_A;
        else if (v < YQ_MIN_A)
            r = YQ_MIN_A;
        else
            r = v;
        return r[YQ_W-1:0];
    endfunction

    function automatic sample_t sat_sample(input acc_t v);
        acc_t r;
        if (v > SAMPLE_MAX_A)
            r = SAMPLE_MAX_A;
        else if (v < SAMPLE_MIN_A)
            r = SAMPLE_MIN_A;
        else
            r = v;
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

/* rtl/mbi_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_in_if / mbi_out_if
// Valid/ready channels for input samples and filtered results.
// ============================================================================
interface mbi_in_if;
    import mbi_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    chan_t   channel;
    logic    block_start;

    modport source (output valid, output sample, output channel, output block_start,
                    input ready);
    modport sink (input valid, input sample, input channel, input block_start,
                  output ready);
endinterface

interface mbi_out_if;
    import mbi_pkg::*;

    logic    valid;
    logic    ready;
    sample_t filtered;
    chan_t   out_channel;

    modport source (output valid, output filtered, output out_channel, input ready);
    modport sink (input valid, input filtered, input out_channel, output ready);
endinterface

/* rtl/mbi_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mbi_regs.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_regs
// APB register file holding the filter gain and feedback coefficients.
// ============================================================================
module mbi_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [mbi_pkg::APB_AW-1:0] paddr,
    input  logic [mbi_pkg::APB_DW-1:0] pwdata,
    output logic [mbi_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output mbi_pkg::cfg_t             cfg
);
    import mbi_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GAIN: cfg_next.gain = coef_t'(pwdata);
                REG_A1:   cfg_next.a1   = coef_t'(pwdata);
                REG_A2:   cfg_next.a2   = coef_t'(pwdata);
                REG_A3:   cfg_next.a3   = coef_t'(pwdata);
                REG_A4:   cfg_next.a4   = coef_t'(pwdata);
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN: prdata = APB_DW'(cfg_reg.gain);
            REG_A1:   prdata = APB_DW'(cfg_reg.a1);
            REG_A2:   prdata = APB_DW'(cfg_reg.a2);
            REG_A3:   prdata = APB_DW'(cfg_reg.a3);
            REG_A4:   prdata = APB_DW'(cfg_reg.a4);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain <= GAIN_RST;
            cfg_reg.a1   <= A1_RST;
            cfg_reg.a2   <= A2_RST;
            cfg_reg.a3   <= A3_RST;
            cfg_reg.a4   <= A4_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/mbi_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_ctrl
// Sequencer: steps one item through load, gain product, quantize, four
// feedback products and write-back; owns the result valid flag.
// ============================================================================
module mbi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    output mbi_pkg::dp_cmd_t cmd
);
    import mbi_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = SEL_GAIN;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // state row arrives; start the gain product
                cmd.load    = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = SEL_GAIN;
                state_next  = ST_GAIN_RND;
            end
            ST_GAIN_RND:
            begin
                state_next = ST_GAIN_ACC;
            end
            ST_GAIN_ACC:
            begin
                state_next = ST_QUANT;
            end
            ST_QUANT:
            begin
                cmd.quant  = 1'b1;
                cnt_next   = '0;
                state_next = ST_FEEDBACK;
            end
            ST_FEEDBACK:
            begin
                cmd.mul_go = 1'b1;
                unique case (cnt_reg)
                    2'd0: cmd.mul_sel = SEL_A1;
                    2'd1: cmd.mul_sel = SEL_A2;
                    2'd2: cmd.mul_sel = SEL_A3;
                    2'd3: cmd.mul_sel = SEL_A4;
                    default: cmd.mul_sel = SEL_A1;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_DRAIN_RND;
                end
            end
            ST_DRAIN_RND:
            begin
                state_next = ST_DRAIN_ACC;
            end
            ST_DRAIN_ACC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register can take the item
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/mbi_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_datapath
// Per-channel delay-word store, shared 32x32 multiplier with rounding and
// accumulate stages, output quantizer and result register.
// ============================================================================
module mbi_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  mbi_pkg::dp_cmd_t cmd,
    input  mbi_pkg::cfg_t    cfg,
    input  mbi_pkg::sample_t in_sample,
    input  mbi_pkg::chan_t   in_channel,
    input  logic             in_block_start,
    output mbi_pkg::sample_t filtered,
    output mbi_pkg::chan_t   out_channel
);
    import mbi_pkg::*;

    // captured item
    sample_t x_reg;
    chan_t   ch_reg;
    logic    bs_reg;

    // delay words: current and updated
    state_t  d_reg  [TAPS];
    state_t  dn_reg [TAPS];
    logic [CHANNELS-1:0] vld_reg;

    // multiplier pipeline
    prod_t    prod_reg;
    mul_sel_t sel1_reg;
    logic     v1_reg;
    state_t   bx_reg;
    state_t   b2xn_reg;
    state_t   pa_reg;
    mul_sel_t sel2_reg;
    logic     v2_reg;

    state_t  y_reg;
    yq_t     yq_reg;
    sample_t filt_reg;
    sample_t filtered_reg;
    chan_t   out_ch_reg;

    logic              ch_ok;
    logic [ADDR_W-1:0] ch_addr;
    logic              row_clear;
    row_t              rd_row;
    row_t              wr_row;
    coef_t             op_a;
    coef_t             op_b;
    prod_t             t_x1;
    prod_t             t_x2;
    prod_t             t_a;

    assign ch_ok     = (CHAN_W+1)'(ch_reg) < (CHAN_W+1)'(CHANNELS);
    assign ch_addr   = ch_reg[ADDR_W-1:0];
    assign row_clear = bs_reg | ~vld_reg[ch_addr];
    assign wr_row    = {dn_reg[3], dn_reg[2], dn_reg[1], dn_reg[0]};

    mbi_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (cmd.commit & ch_ok),
        .waddr (ch_addr),
        .wdata (wr_row),
        .re    (cmd.capture),
        .raddr (in_channel[ADDR_W-1:0]),
        .rdata (rd_row)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            SEL_GAIN: op_a = cfg.gain;
            SEL_A1:   op_a = cfg.a1;
            SEL_A2:   op_a = cfg.a2;
            SEL_A3:   op_a = cfg.a3;
            SEL_A4:   op_a = cfg.a4;
            default:  op_a = cfg.gain;
        endcase
        op_b = (cmd.mul_sel == SEL_GAIN) ? coef_t'(x_reg) : coef_t'(yq_reg);
    end

    // round half up: add half an LSB, then arithmetic shift
    assign t_x1 = prod_reg + (prod_t'(1) <<< (SX - 1));
    assign t_x2 = prod_reg + (prod_t'(1) <<< (SX - 2));
    assign t_a  = prod_reg + (prod_t'(1) <<< (SY - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.mul_go;
            v2_reg <= v1_reg;
            if (cmd.commit && ch_ok)
            begin
                vld_reg[ch_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg  <= in_sample;
            ch_reg <= in_channel;
            bs_reg <= in_block_start;
        end

        if (cmd.load)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                d_reg[k] <= row_clear ? '0 : state_t'(rd_row[k*STATE_W +: STATE_W]);
            end
        end

        if (cmd.mul_go)
        begin
            prod_reg <= prod_t'(op_a) * prod_t'(op_b);
            sel1_reg <= cmd.mul_sel;
        end

        if (v1_reg)
        begin
            sel2_reg <= sel1_reg;
            if (sel1_reg == SEL_GAIN)
            begin
                bx_reg   <= state_t'(t_x1 >>> SX);
                b2xn_reg <= state_t'(-(t_x2 >>> (SX - 1)));
            end
            else
            begin
                pa_reg <= state_t'(t_a >>> SY);
            end
        end

        if (v2_reg)
        begin
            unique case (sel2_reg)
                SEL_GAIN: y_reg <= sat_state(acc_t'(d_reg[0]) + acc_t'(bx_reg));
                SEL_A1:   dn_reg[0] <= sat_state(acc_t'(d_reg[1]) - acc_t'(pa_reg));
                SEL_A2:   dn_reg[1] <= sat_state(acc_t'(d_reg[2]) + acc_t'(b2xn_reg)
                                                 - acc_t'(pa_reg));
                SEL_A3:   dn_reg[2] <= sat_state(acc_t'(d_reg[3]) - acc_t'(pa_reg));
                SEL_A4:   dn_reg[3] <= sat_state(acc_t'(bx_reg) - acc_t'(pa_reg));
                default:  y_reg <= y_reg;
            endcase
        end

        if (cmd.quant)
        begin
            yq_reg   <= sat_yq((acc_t'(y_reg) + YQ_HALF) >>> YQ_SHIFT);
            filt_reg <= ch_ok ? sat_sample((acc_t'(y_reg) + OUT_HALF) >>> STATE_FRAC)
                              : '0;
        end

        if (cmd.commit)
        begin
            filtered_reg <= filt_reg;
            out_ch_reg   <= ch_reg;
        end
    end

    assign filtered    = filtered_reg;
    assign out_channel = out_ch_reg;

endmodule

/* rtl/multichannel_bandpass_iir_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// multichannel_bandpass_iir_unit
// Eight-channel fourth-order band-pass IIR (transposed direct form II) with
// per-channel state, block-start clearing and 24-bit saturated output.
// ============================================================================
//
//  port      | dir | handshake    | payload
//  ----------+-----+--------------+---------------------------------------
//  din       | in  | valid/ready  | sample[23:0], channel[2:0], block_start
//  dout      | out | valid/ready  | filtered[23:0], out_channel[2:0]
//  APB       | in  | psel/penable | paddr[4:0], pwdata/prdata[31:0]
//
//  An item passes, from acceptance to the next possible acceptance, through
//  one state-row read, the gain product, quantize, then four feedback
//  products through the single 32x32 multiplier with a round and an
//  accumulate stage behind it, and the write-back.
//  Reset clears the per-channel valid bits, so no clearing pass is needed.
//  The finished item sits in the output register; the next item is taken
//  while it waits, and only the write-back stalls if it is still unread.
//
module multichannel_bandpass_iir_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    mbi_in_if.sink                    din,
    mbi_out_if.source                 dout,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [mbi_pkg::APB_AW-1:0] paddr,
    input  logic [mbi_pkg::APB_DW-1:0] pwdata,
    output logic [mbi_pkg::APB_DW-1:0] prdata,
    output logic                      pready
);
    import mbi_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    logic    in_ready;
    logic    out_valid;
    sample_t filtered;
    chan_t   out_channel;

    mbi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (in_ready),
        .out_ready (dout.ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mbi_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .in_sample      (din.sample),
        .in_channel     (din.channel),
        .in_block_start (din.block_start),
        .filtered       (filtered),
        .out_channel    (out_channel)
    );

    assign din.ready        = in_ready;
    assign dout.valid       = out_valid;
    assign dout.filtered    = filtered;
    assign dout.out_channel = out_channel;

endmodule

/* rtl/mbi_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_checker
// Port-level checks on the band-pass IIR unit, bound to the top level.
// ============================================================================
module mbi_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [mbi_pkg::SAMPLE_W-1:0] filtered,
    input logic [mbi_pkg::CHAN_W-1:0]   out_channel
);
    import mbi_pkg::*;

    // one item in work at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready stayed high after an accepted item");

    // ready only drops because an item was taken
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without an accepted item");

    // a new result only comes out of an item in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while no item was in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(filtered) && $stable(out_channel))
        else $error("stalled result changed");

endmodule

bind multichannel_bandpass_iir_unit mbi_checker u_mbi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (din.valid),
    .in_ready    (din.ready),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .filtered    (dout.filtered),
    .out_channel (dout.out_channel)
);

/* tb/mbi_tb_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// mbi_tb_pkg
// Scoreboard for the multichannel band-pass IIR: keeps its own copy of the
// coefficients and per-channel delay words and predicts each filtered item.
// ============================================================================
package mbi_tb_pkg;
    import mbi_pkg::*;

    typedef struct {
        sample_t filtered;
        chan_t   channel;
    } filter_out_t;

    class bandpass_scoreboard;
        localparam longint WIDE_LIM = longint'(1) <<< 50;
        localparam longint STATE_HI = (longint'(1) <<< (STATE_W - 1)) - 1;
        localparam longint STATE_LO = -(longint'(1) <<< (STATE_W - 1));
        localparam longint YQ_HI    = (longint'(1) <<< (YQ_W - 1)) - 1;
        localparam longint YQ_LO    = -(longint'(1) <<< (YQ_W - 1));
        localparam longint OUT_HI   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        localparam longint OUT_LO   = -(longint'(1) <<< (SAMPLE_W - 1));

        coef_t       gain;
        coef_t       a1;
        coef_t       a2;
        coef_t       a3;
        coef_t       a4;
        state_t      delay_words[CHANNELS][TAPS];
        filter_out_t pending_outputs[$];
        int          errors;

        function new();
            gain = GAIN_RST;
            a1   = A1_RST;
            a2   = A2_RST;
            a3   = A3_RST;
            a4   = A4_RST;
            errors = 0;
            foreach (delay_words[c, k])
                delay_words[c][k] = '0;
        endfunction

        function void set_reg(reg_idx_t idx, coef_t value);
            case (idx)
                REG_GAIN: gain = value;
                REG_A1:   a1   = value;
                REG_A2:   a2   = value;
                REG_A3:   a3   = value;
                REG_A4:   a4   = value;
                default:  ;
            endcase
        endfunction

        // Shift right, rounding half toward plus infinity
        function longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint scaled_product(coef_t c, longint v, int s);
            return clamp(round_shift(longint'(c) * v, s), -WIDE_LIM, WIDE_LIM);
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // Append an expected item at the tail
        function void queue_expected(filter_out_t e);
            pending_outputs = {pending_outputs, e};
        endfunction

        // Filter one accepted item and queue the expected output
        function void note_sample(sample_t x, chan_t ch, logic block_start);
            filter_out_t exp_out;
            longint      xs;
            longint      bx;
            longint      b2x;
            longint      y;
            longint      yq;
            longint      d[TAPS];
            exp_out.channel = ch;
            if (int'(ch) >= CHANNELS)
            begin
                exp_out.filtered = '0;
                queue_expected(exp_out);
                return;
            end
            if (block_start)
                for (int k = 0; k < TAPS; k++)
                    delay_words[ch][k] = '0;
            foreach (d[k])
                d[k] = longint'(delay_words[ch][k]);
            xs  = longint'(x);
            bx  = scaled_product(gain, xs, SX);
            // doubling folds into one less bit of shift
            b2x = -scaled_product(gain, xs, SX - 1);
            y   = clamp(d[0] + bx, STATE_LO, STATE_HI);
            yq  = clamp(round_shift(y, YQ_SHIFT), YQ_LO, YQ_HI);
            delay_words[ch][0] = state_t'(clamp(d[1] - scaled_product(a1, yq, SY),
                                                STATE_LO, STATE_HI));
            delay_words[ch][1] = state_t'(clamp(d[2] + b2x - scaled_product(a2, yq, SY),
                                                STATE_LO, STATE_HI));
            delay_words[ch][2] = state_t'(clamp(d[3] - scaled_product(a3, yq, SY),
                                                STATE_LO, STATE_HI));
            delay_words[ch][3] = state_t'(clamp(bx - scaled_product(a4, yq, SY),
                                                STATE_LO, STATE_HI));
            exp_out.filtered = sample_t'(clamp(round_shift(y, STATE_FRAC), OUT_LO, OUT_HI));
            queue_expected(exp_out);
        endfunction

        function void check_output(sample_t filtered, chan_t channel);
            filter_out_t exp_out;
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected item: filtered %0d, out_channel %0d", filtered, channel);
                errors++;
                return;
            end
            exp_out = pending_outputs.pop_front();
            if (filtered !== exp_out.filtered)
            begin
                $error("filtered mismatch: expected %0d, actual %0d",
                       exp_out.filtered, filtered);
                errors++;
            end
            if (channel !== exp_out.channel)
            begin
                $error("out_channel mismatch: expected %0d, actual %0d",
                       exp_out.channel, channel);
                errors++;
            end
        endfunction
    endclass

endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Drives interleaved multichannel samples through the band-pass IIR under
// several coefficient sets and random stalls, checking every filtered item.
// ============================================================================
module tb;
    import mbi_pkg::*;
    import mbi_tb_pkg::*;

    localparam int      CYCLE_LIMIT     = 400000;
    localparam int      SETTLE_CYCLES   = 16;
    localparam int      ITEMS_PER_PHASE = 200;
    localparam int      PHASES          = 6;
    localparam int      BLOCK_LEN       = 60;
    localparam int      REG_STRIDE      = 4;
    localparam int      ADDR_SLOTS      = (1 << APB_AW) / REG_STRIDE;
    localparam sample_t S_MAX           = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t S_MIN           = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam coef_t   C_MAX           = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t   C_MIN           = {1'b1, {(COEF_W-1){1'b0}}};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 cycle_count = 0;
    bandpass_scoreboard sb = new();

    mbi_in_if  din_if();
    mbi_out_if dout_if();

    multichannel_bandpass_iir_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Predict on every accepted input item
    always @(posedge clk)
    begin
        if (din_if.valid === 1'b1 && din_if.ready === 1'b1)
            sb.note_sample(din_if.sample, din_if.channel, din_if.block_start);
    end

    initial
    begin
        dout_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
                sb.check_output(dout_if.filtered, dout_if.out_channel);
            dout_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic write_reg(input int idx, input coef_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * REG_STRIDE);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_REGS)
            sb.set_reg(reg_idx_t'(idx), value);
        // return to idle with psel low before the next write can start
        @(posedge clk);
    endtask

    task automatic apply_coefs(input coef_t g, input coef_t c1, input coef_t c2,
                               input coef_t c3, input coef_t c4);
        write_reg(REG_GAIN, g);
        write_reg(REG_A1, c1);
        write_reg(REG_A2, c2);
        write_reg(REG_A3, c3);
        write_reg(REG_A4, c4);
        // unmapped slot: must be dropped
        write_reg($urandom_range(NUM_REGS, ADDR_SLOTS - 1), coef_t'($urandom));
    endtask

    task automatic send_item(input sample_t s, input chan_t c, input logic bs);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            din_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        din_if.valid       <= 1'b1;
        din_if.sample      <= s;
        din_if.channel     <= c;
        din_if.block_start <= bs;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
            1:       return ($urandom_range(0, 1) != 0) ? sample_t'(0) : sample_t'(-1);
            2, 3, 4: return sample_t'($urandom);
            default: return sample_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    // Mostly well-formed interleaved blocks, with stray channels and flags mixed in
    task automatic run_blocks(input int count);
        int    pos[CHANNELS];
        int    blk_len[CHANNELS];
        int    ch;
        logic  bs;
        ch = 0;
        foreach (pos[k])
        begin
            pos[k]     = 0;
            blk_len[k] = BLOCK_LEN;
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) != 0)
                ch = (ch + 1) % CHANNELS;
            else
                ch = $urandom_range(0, CHANNELS - 1);
            if (pos[ch] == 0)
                blk_len[ch] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, BLOCK_LEN)
                                                          : BLOCK_LEN;
            bs = (pos[ch] == 0);
            if ($urandom_range(0, 19) == 0)
                bs = ~bs;
            send_item(pick_sample(), chan_t'(ch), bs);
            pos[ch] = (pos[ch] + 1) % blk_len[ch];
        end
    endtask

    initial
    begin
        din_if.valid       = 1'b0;
        din_if.sample      = '0;
        din_if.channel     = '0;
        din_if.block_start = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        rst_n              = 1'b0;
        src_idle_pct       = 23;
        sink_idle_pct      = 68;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset coefficients, field extremes, every channel, restarts
        send_item(S_MAX, 3'd0, 1'b1);
        send_item(S_MAX, 3'd0, 1'b0);
        send_item(S_MAX, 3'd0, 1'b0);
        send_item(S_MIN, 3'd1, 1'b1);
        send_item(S_MIN, 3'd1, 1'b0);
        send_item(sample_t'(0), 3'd2, 1'b1);
        send_item(sample_t'(-1), 3'd2, 1'b0);
        send_item(sample_t'(1), 3'd3, 1'b1);
        send_item(sample_t'(24'h555555), 3'd3, 1'b0);
        send_item(sample_t'(24'hAAAAAA), 3'd4, 1'b1);
        send_item(S_MAX, 3'd5, 1'b1);
        send_item(S_MIN, 3'd6, 1'b1);
        send_item(S_MAX, 3'd7, 1'b1);
        send_item(S_MIN, 3'd7, 1'b0);
        send_item(S_MIN, 3'd0, 1'b0);
        send_item(S_MIN, 3'd0, 1'b1);
        send_item(S_MAX, 3'd1, 1'b0);
        send_item(S_MIN, 3'd5, 1'b0);
        send_item(S_MAX, 3'd6, 1'b0);
        send_item(sample_t'(-1), 3'd4, 1'b0);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                src_idle_pct  = 23;
                sink_idle_pct = 68;
            end
            else if (p < 4)
            begin
                src_idle_pct  = 68;
                sink_idle_pct = 23;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (p)
                0:       apply_coefs(GAIN_RST, A1_RST, A2_RST, A3_RST, A4_RST);
                1:       apply_coefs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
                2:       apply_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
                3:       apply_coefs(C_MAX, '0, '0, '0, '0);
                4:       apply_coefs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                                     coef_t'($urandom), coef_t'($urandom));
                default: apply_coefs(GAIN_RST <<< 5, A1_RST, A2_RST, A3_RST, A4_RST);
            endcase
            run_blocks(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/mbi_pkg.sv
rtl/mbi_if.sv
rtl/mbi_ram.sv
rtl/mbi_regs.sv
rtl/mbi_ctrl.sv
rtl/mbi_datapath.sv
rtl/multichannel_bandpass_iir_unit.sv
rtl/mbi_checker.sv
tb/mbi_tb_pkg.sv
tb/tb.sv
